// File: rtl/core/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, codes and the factory word image of the serial EEPROM.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  // Geometry of the word store
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned WORDS     = 1 << ADDR_W;
  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_BITS - 1);

  // Bus access codes
  localparam logic [1:0] MODE_DIR_WR  = 2'd0;
  localparam logic [1:0] MODE_DATA_WR = 2'd1;
  localparam logic [1:0] MODE_DATA_RD = 2'd2;

  // Protocol command codes
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Fields of a written byte
  localparam logic [7:0] SEL_MASK  = 8'hC0;
  localparam logic [7:0] DIR_MASK  = 8'h30;
  localparam logic [7:0] DIR_READY = 8'h20;
  localparam int unsigned DIN_BIT  = 5;
  localparam int unsigned DOUT_BIT = 4;

  typedef enum logic [3:0] {
    PH_READY = 4'd0,
    PH_OP0   = 4'd1,
    PH_OP1   = 4'd2,
    PH_ADDR0 = 4'd3,
    PH_ADDR1 = 4'd4,
    PH_ADDR2 = 4'd5,
    PH_ADDR3 = 4'd6,
    PH_ADDR4 = 4'd7,
    PH_ADDR5 = 4'd8,
    PH_DATA  = 4'd9
  } phase_e;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // Factory contents; words outside the list read as zero
  function automatic word_t image_word(input addr_t a);
    word_t w;
    case (a)
      addr_t'(0):  w = word_t'(16'h6D76);
      addr_t'(1):  w = word_t'(16'h6361);
      addr_t'(2):  w = word_t'(16'h3130);
      addr_t'(3):  w = word_t'(16'h0207);
      addr_t'(9):  w = word_t'(16'h0010);
      addr_t'(16): w = word_t'(16'h1000);
      addr_t'(24): w = word_t'(16'h0010);
      default:     w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/bitbang_serial_eeprom.sv
// ----------------------------------------------------------------------------
// bitbang_serial_eeprom
// 64 x 16 serial EEPROM driven bit by bit through direction and data ports.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid_i, in_stall_o, mode_i, | into block
//          | value_i                         |
//  out     | out_valid_o, out_stall_i,       | out of block
//          | read_byte_o                     |
//
//  One request per cycle while in_stall_o is low; its result appears in the
//  output register on the next cycle. The word at the current address is read
//  from the RAM ahead of use (read address follows the next address), with a
//  bypass for a word written at the same edge. Reset restores the factory image
//  at once through one valid bit per word. in_stall_o is high only while a
//  result waits under out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module bitbang_serial_eeprom (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] read_byte_o
);

  bse_pkg::phase_e phase_q, phase_d;
  logic [1:0]      cmd_q, cmd_d;
  bse_pkg::addr_t  addr_q, addr_d;
  logic [bse_pkg::BIT_W-1:0] bit_q, bit_d;
  logic            dummy_q, dummy_d;

  logic [bse_pkg::WORDS-1:0] valid_q;
  logic            fwd_q;
  bse_pkg::word_t  fwd_data_q;
  bse_pkg::word_t  ram_rdata, ram_wdata, cur_word;
  logic            ram_we;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      read_byte_q, read_byte_d;

  logic            accept, qual, din;
  logic [bse_pkg::BIT_W-1:0] pos, bit_adv;
  bse_pkg::addr_t  addr_adv;
  logic [2:0]      apos;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign qual       = (value_i & bse_pkg::SEL_MASK) == bse_pkg::SEL_MASK;
  assign din        = value_i[bse_pkg::DIN_BIT];
  assign pos        = bse_pkg::BIT_LAST - bit_q;
  assign bit_adv    = (bit_q == bse_pkg::BIT_LAST) ? '0 : bit_q + 1'b1;
  assign addr_adv   = (bit_q == bse_pkg::BIT_LAST) ? addr_q + 1'b1 : addr_q;
  // address bits arrive most significant first
  assign apos       = 3'(bse_pkg::ADDR_W - 1) - 3'(phase_q - bse_pkg::PH_ADDR0);

  assign cur_word = fwd_q ? fwd_data_q :
                    (valid_q[addr_q] ? ram_rdata : bse_pkg::image_word(addr_q));

  bse_ram #(
    .WIDTH(bse_pkg::WORD_BITS),
    .DEPTH(bse_pkg::WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  // Next protocol state
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    bit_d   = bit_q;
    dummy_d = dummy_q;
    if (accept) begin
      case (mode_i)
        bse_pkg::MODE_DIR_WR: begin
          if (qual && ((value_i & bse_pkg::DIR_MASK) == bse_pkg::DIR_READY)) begin
            phase_d = bse_pkg::PH_READY;
          end
        end
        bse_pkg::MODE_DATA_WR: begin
          if (qual) begin
            case (phase_q)
              bse_pkg::PH_READY: begin
                cmd_d   = '0;
                phase_d = bse_pkg::PH_OP0;
              end
              bse_pkg::PH_OP0: begin
                cmd_d   = {din, 1'b0};
                phase_d = bse_pkg::PH_OP1;
                bit_d   = '0;
                dummy_d = 1'b1;
              end
              bse_pkg::PH_OP1: begin
                cmd_d[0] = din;
                phase_d  = bse_pkg::PH_ADDR0;
              end
              bse_pkg::PH_ADDR0, bse_pkg::PH_ADDR1, bse_pkg::PH_ADDR2,
              bse_pkg::PH_ADDR3, bse_pkg::PH_ADDR4, bse_pkg::PH_ADDR5: begin
                addr_d[apos] = din;
                phase_d      = bse_pkg::phase_e'(phase_q + 4'd1);
              end
              bse_pkg::PH_DATA: begin
                if (cmd_q == bse_pkg::CMD_WRITE) begin
                  dummy_d = 1'b0;
                  bit_d   = bit_adv;
                  addr_d  = addr_adv;
                end
              end
              default: begin
              end
            endcase
          end
        end
        bse_pkg::MODE_DATA_RD: begin
          if (phase_q == bse_pkg::PH_DATA && cmd_q == bse_pkg::CMD_READ) begin
            if (dummy_q) begin
              dummy_d = 1'b0;
              bit_d   = '0;
            end else begin
              bit_d  = bit_adv;
              addr_d = addr_adv;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Store write and read data
  always_comb begin
    read_byte_d = '0;
    ram_we      = 1'b0;
    ram_wdata   = cur_word;
    if (accept && phase_q == bse_pkg::PH_DATA) begin
      if (mode_i == bse_pkg::MODE_DATA_WR && qual && cmd_q == bse_pkg::CMD_WRITE) begin
        ram_we         = 1'b1;
        ram_wdata[pos] = din;
      end
      if (mode_i == bse_pkg::MODE_DATA_RD && cmd_q == bse_pkg::CMD_READ && !dummy_q) begin
        read_byte_d[bse_pkg::DOUT_BIT] = cur_word[pos];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bse_pkg::PH_READY;
      cmd_q       <= '0;
      addr_q      <= '0;
      bit_q       <= '0;
      dummy_q     <= 1'b0;
      valid_q     <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      addr_q      <= addr_d;
      bit_q       <= bit_d;
      dummy_q     <= dummy_d;
      out_valid_q <= out_valid_d;
      // bypass a word written at the edge that also reads it
      fwd_q       <= ram_we && (addr_q == addr_d);
      if (ram_we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
    if (accept) begin
      read_byte_q <= read_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;

endmodule

`default_nettype wire

// File: rtl/core/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_assert
// Port-level checks for the serial EEPROM, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_assert (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic [7:0] value_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] read_byte_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_byte_o))
    else $error("stalled result changed");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(mode_i) && $stable(value_i))
    else $error("stalled request changed");

  // every request yields a result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("request without result");

  // anything but a data read answers zero
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_i != bse_pkg::MODE_DATA_RD) |=> read_byte_o == 8'h00)
    else $error("non-read returned data");

  // stall only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

endmodule

bind bitbang_serial_eeprom bse_assert u_bse_assert (.*);

`default_nettype wire
